[src/ccp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the combined coordinate parser.
// No dependencies; imported by ccp_parser, ccp_scaler and the top level.
package ccp_pkg;

    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] POS_LAT_HEMI  = 4'd0;
    localparam logic [3:0] POS_LAT_LAST  = 4'd5;
    localparam logic [3:0] POS_LAT_DEG   = 4'd2;
    localparam logic [3:0] POS_MIDDLE    = 4'd6;
    localparam logic [3:0] POS_LON_FIRST = 4'd7;
    localparam logic [3:0] POS_LON_LAST  = 4'd12;
    localparam logic [3:0] POS_LON_SPACE = 4'd13;
    localparam logic [3:0] POS_MAX       = 4'd15;
    localparam logic [3:0] LEN_PLAIN     = 4'd13;
    localparam logic [3:0] LEN_SPACED    = 4'd14;
    localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

    localparam logic [23:0] DEG_SCALE     = 24'd10000000;
    localparam logic [13:0] PLAIN_T_SCALE = 14'd10000;
    localparam logic [14:0] DM_T_SCALE    = 15'd16666;
    localparam logic [9:0]  RECIP3        = 10'd683;

    typedef struct packed {
        logic       ok;
        logic       lat_south;
        logic       lon_west;
        logic       dec_min;
        logic [6:0] lat_deg;
        logic [9:0] lat_t;
        logic [9:0] lon_deg;
        logic [9:0] lon_t;
    } capture_t;

    typedef struct packed {
        logic        ok;
        logic        lat_south;
        logic        lon_west;
        logic [30:0] lat_a;
        logic [23:0] lat_b;
        logic [33:0] lon_a;
        logic [23:0] lon_b;
    } products_t;

endpackage

[src/combined_coordinate_parser.sv]
`timescale 1ns / 1ps
// A result passes through three registers after the accepted last byte: parse capture,
// scaling products, then the sign/sum output register. Throughput is one byte per cycle;
// the three-stage pipeline advances whenever the output register is empty or taken.
// Reset (rst_n, async low) clears parse state, pipeline valids and decimal_minutes.
// Depends on ccp_pkg, ccp_parser and ccp_scaler.
module combined_coordinate_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [30:0] latitude, [65:31] longitude, [71:66] zero
    output logic        m_tuser,   // valid_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // decimal_minutes
);
    import ccp_pkg::*;

    logic        advance;
    logic        accept;
    logic        dec_min_reg;
    logic        cap_valid;
    capture_t    cap;
    logic        prod_valid;
    products_t   prod;

    logic        out_valid_reg, out_valid_next;
    logic        ok_reg;
    logic [30:0] lat_reg, lat_next;
    logic [34:0] lon_reg, lon_next;
    logic [30:0] lat_mag;
    logic [34:0] lon_mag;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_min_reg <= 1'b0;
        else if (cfg_valid)
            dec_min_reg <= cfg_data;
    end

    ccp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .char_byte (s_tdata),
        .last      (s_tlast),
        .dec_min   (dec_min_reg),
        .cap_valid (cap_valid),
        .cap       (cap)
    );

    ccp_scaler u_scaler
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cap_valid  (cap_valid),
        .cap        (cap),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    always_comb
    begin
        lat_mag = prod.lat_a + 31'(prod.lat_b);
        lon_mag = 35'(prod.lon_a) + 35'(prod.lon_b);

        if (!prod.ok)
            lat_next = '0;
        else if (prod.lat_south)
            lat_next = -lat_mag;
        else
            lat_next = lat_mag;

        if (!prod.ok)
            lon_next = '0;
        else if (prod.lon_west)
            lon_next = -lon_mag;
        else
            lon_next = lon_mag;

        out_valid_next = advance ? prod_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && prod_valid)
        begin
            ok_reg  <= prod.ok;
            lat_reg <= lat_next;
            lon_reg <= lon_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {6'd0, lon_reg, lat_reg};

endmodule

[src/ccp_parser.sv]
`timescale 1ns / 1ps
// Character parser: per-byte format check and digit accumulation.
// Depends on ccp_pkg; captures the finished fields on the last byte.
module ccp_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               advance,
    input  logic [7:0]         char_byte,
    input  logic               last,
    input  logic               dec_min,
    output logic               cap_valid,
    output ccp_pkg::capture_t  cap
);
    import ccp_pkg::*;

    logic [3:0] pos_reg, pos_next, pos_upd;
    logic       sp_reg, sp_next, sp_upd;
    logic       south_reg, south_next, south_upd;
    logic       west_reg, west_next, west_upd;
    logic       fmt_reg, fmt_next, fmt_upd;
    logic [6:0] lat_deg_reg, lat_deg_next, lat_deg_upd;
    logic [9:0] lat_t_reg, lat_t_next, lat_t_upd;
    logic [9:0] lon_deg_reg, lon_deg_next, lon_deg_upd;
    logic [9:0] lon_t_reg, lon_t_next, lon_t_upd;
    logic       cap_valid_reg, cap_valid_next;
    capture_t   cap_reg, cap_next;

    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] lon_k;
    logic       take_middle;
    logic       take_lon;
    logic [3:0] needed;

    always_comb
    begin
        is_digit    = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        digit       = char_byte[3:0];
        lon_k       = pos_reg - POS_LON_FIRST - {3'd0, sp_reg};
        take_middle = 1'b0;
        take_lon    = 1'b0;

        pos_upd     = pos_reg;
        sp_upd      = sp_reg;
        south_upd   = south_reg;
        west_upd    = west_reg;
        fmt_upd     = fmt_reg;
        lat_deg_upd = lat_deg_reg;
        lat_t_upd   = lat_t_reg;
        lon_deg_upd = lon_deg_reg;
        lon_t_upd   = lon_t_reg;

        if (pos_reg == POS_LAT_HEMI)
        begin
            if (char_byte == CH_N)
                south_upd = 1'b0;
            else if (char_byte == CH_S)
                south_upd = 1'b1;
            else
                fmt_upd = 1'b0;
        end
        else if (pos_reg <= POS_LAT_LAST)
        begin
            if (!is_digit)
                fmt_upd = 1'b0;
            else if (pos_reg <= POS_LAT_DEG)
                lat_deg_upd = 7'(lat_deg_reg * 7'd10 + 7'(digit));
            else
                lat_t_upd = 10'(lat_t_reg * 10'd10 + 10'(digit));
        end
        else if (pos_reg == POS_MIDDLE)
        begin
            if (char_byte == CH_SPACE)
                sp_upd = 1'b1;
            else
                take_middle = 1'b1;
        end
        else if (pos_reg == POS_LON_FIRST)
        begin
            take_middle = sp_reg;
            take_lon    = !sp_reg;
        end
        else if (pos_reg <= POS_LON_LAST)
        begin
            take_lon = 1'b1;
        end
        else if (pos_reg == POS_LON_SPACE)
        begin
            take_lon = sp_reg;
        end

        if (take_middle)
        begin
            if (char_byte == CH_E)
                west_upd = 1'b0;
            else if (char_byte == CH_W)
                west_upd = 1'b1;
            else
                fmt_upd = 1'b0;
        end

        if (take_lon)
        begin
            if (!is_digit)
                fmt_upd = 1'b0;
            else if (lon_k < LON_DEG_DIGITS)
                lon_deg_upd = 10'(lon_deg_reg * 10'd10 + 10'(digit));
            else
                lon_t_upd = 10'(lon_t_reg * 10'd10 + 10'(digit));
        end

        if (pos_reg != POS_MAX)
            pos_upd = pos_reg + 4'd1;

        needed = sp_upd ? LEN_SPACED : LEN_PLAIN;

        cap_next.ok        = fmt_upd && (pos_upd >= needed);
        cap_next.lat_south = south_upd;
        cap_next.lon_west  = west_upd;
        cap_next.dec_min   = dec_min;
        cap_next.lat_deg   = lat_deg_upd;
        cap_next.lat_t     = lat_t_upd;
        cap_next.lon_deg   = lon_deg_upd;
        cap_next.lon_t     = lon_t_upd;

        pos_next     = pos_reg;
        sp_next      = sp_reg;
        south_next   = south_reg;
        west_next    = west_reg;
        fmt_next     = fmt_reg;
        lat_deg_next = lat_deg_reg;
        lat_t_next   = lat_t_reg;
        lon_deg_next = lon_deg_reg;
        lon_t_next   = lon_t_reg;

        if (accept)
        begin
            if (last)
            begin
                pos_next     = 4'd0;
                sp_next      = 1'b0;
                south_next   = 1'b0;
                west_next    = 1'b0;
                fmt_next     = 1'b1;
                lat_deg_next = '0;
                lat_t_next   = '0;
                lon_deg_next = '0;
                lon_t_next   = '0;
            end
            else
            begin
                pos_next     = pos_upd;
                sp_next      = sp_upd;
                south_next   = south_upd;
                west_next    = west_upd;
                fmt_next     = fmt_upd;
                lat_deg_next = lat_deg_upd;
                lat_t_next   = lat_t_upd;
                lon_deg_next = lon_deg_upd;
                lon_t_next   = lon_t_upd;
            end
        end

        cap_valid_next = advance ? (accept && last) : cap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sp_reg        <= 1'b0;
            south_reg     <= 1'b0;
            west_reg      <= 1'b0;
            fmt_reg       <= 1'b1;
            lat_deg_reg   <= '0;
            lat_t_reg     <= '0;
            lon_deg_reg   <= '0;
            lon_t_reg     <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sp_reg        <= sp_next;
            south_reg     <= south_next;
            west_reg      <= west_next;
            fmt_reg       <= fmt_next;
            lat_deg_reg   <= lat_deg_next;
            lat_t_reg     <= lat_t_next;
            lon_deg_reg   <= lon_deg_next;
            lon_t_reg     <= lon_t_next;
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
            cap_reg <= cap_next;
    end

    assign cap_valid = cap_valid_reg;
    assign cap       = cap_reg;

endmodule

[src/ccp_scaler.sv]
`timescale 1ns / 1ps
// Scaling stage: degree and fraction products in 1e-7 degree units.
// Depends on ccp_pkg; fraction rounding uses a reciprocal-of-3 multiply.
module ccp_scaler
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                cap_valid,
    input  ccp_pkg::capture_t   cap,
    output logic                prod_valid,
    output ccp_pkg::products_t  prod
);
    import ccp_pkg::*;

    logic      prod_valid_reg, prod_valid_next;
    products_t prod_reg, prod_next;

    logic [20:0] lat_q_prod, lon_q_prod;
    logic [23:0] lat_frac, lon_frac;

    always_comb
    begin
        // (2t+1)/3 for t below 1000
        lat_q_prod = 21'({cap.lat_t, 1'b1}) * 21'(RECIP3);
        lon_q_prod = 21'({cap.lon_t, 1'b1}) * 21'(RECIP3);

        if (cap.dec_min)
        begin
            lat_frac = 24'(cap.lat_t) * 24'(DM_T_SCALE) + 24'(lat_q_prod[20:11]);
            lon_frac = 24'(cap.lon_t) * 24'(DM_T_SCALE) + 24'(lon_q_prod[20:11]);
        end
        else
        begin
            lat_frac = 24'(cap.lat_t) * 24'(PLAIN_T_SCALE);
            lon_frac = 24'(cap.lon_t) * 24'(PLAIN_T_SCALE);
        end

        prod_next.ok        = cap.ok;
        prod_next.lat_south = cap.lat_south;
        prod_next.lon_west  = cap.lon_west;
        prod_next.lat_a     = 31'(cap.lat_deg) * 31'(DEG_SCALE);
        prod_next.lat_b     = lat_frac;
        prod_next.lon_a     = 34'(cap.lon_deg) * 34'(DEG_SCALE);
        prod_next.lon_b     = lon_frac;

        prod_valid_next = advance ? cap_valid : prod_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= prod_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && cap_valid)
            prod_reg <= prod_next;
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

[src/ccp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for combined_coordinate_parser.
// Bound to the top level; depends only on its ports.
module ccp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // stalled transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 72'd0)
        else $error("invalid result carries nonzero coordinates");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[30:0]) <= 31'sd1006650000)
                  && ($signed(m_tdata[30:0]) >= -31'sd1006650000))
        else $error("latitude out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind combined_coordinate_parser ccp_checker u_ccp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
